FILE: design/rrlp_pkg.sv
// rrlp_pkg: shared constants and helpers for the range line parser
// character codes, prefix text, number phase codes and default settings
// no dependencies

package rrlp_pkg;

    localparam int unsigned LINE_CAPACITY_DEF = 64;
    localparam int unsigned PREFIX_LEN        = 6;

    localparam logic [31:0] MIN_DISTANCE_RST = 32'd0;
    localparam logic [31:0] MAX_DISTANCE_RST = 32'd800;

    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_VT    = 8'h0B;
    localparam logic [7:0] CHAR_FF    = 8'h0C;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;

    // number phase codes
    localparam logic [1:0] PH_BLANKS = 2'd0;
    localparam logic [1:0] PH_SIGN   = 2'd1;
    localparam logic [1:0] PH_DIGITS = 2'd2;
    localparam logic [1:0] PH_DONE   = 2'd3;

    // configuration register indexes
    localparam logic REG_MIN_DISTANCE = 1'b0;
    localparam logic REG_MAX_DISTANCE = 1'b1;

    // magnitude clamp value, 2^31
    localparam logic [31:0] MAG_LIMIT = 32'h8000_0000;

    typedef struct packed {
        logic signed [31:0] range_cm;
        logic               detecting;
        logic               state_changed;
    } result_t;

    // expected byte of the "Range " prefix at a given line position
    function automatic logic [7:0] prefix_char(input logic [2:0] idx);
        logic [7:0] c;
        unique case (idx)
            3'd0:    c = 8'h52; // R
            3'd1:    c = 8'h61; // a
            3'd2:    c = 8'h6E; // n
            3'd3:    c = 8'h67; // g
            3'd4:    c = 8'h65; // e
            3'd5:    c = 8'h20; // space
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

FILE: design/radar_range_line_parser.sv
// radar_range_line_parser: byte-wise parser of "Range <n>" text lines
// checks the prefix, parses a saturating decimal number, range-checks on newline
// depends on rrlp_pkg
//
// an accepted byte is held in the input register and then parsed into the parser
// state; a newline's result is loaded into the output register as it is parsed
// throughput: one byte per cycle, set by the single registered parse stage; a
// newline waits only while the output register holds an untaken result
// reset: asynchronous, active low; clears parser state, detection state, valid
// flags and restores min_distance 0 and max_distance 800

module radar_range_line_parser
    import rrlp_pkg::*;
#(
    parameter int unsigned LINE_CAPACITY = LINE_CAPACITY_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,

    // input byte stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte

    // result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // [31:0] range_cm, [32] detecting,
                                        // [33] state_changed, [39:34] zero

    // configuration writes
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,      // 0 min_distance, 1 max_distance
    input  logic [31:0] cfg_data
);

    localparam int unsigned POS_W = $clog2(LINE_CAPACITY);
    localparam logic [POS_W-1:0] POS_LAST   = POS_W'(LINE_CAPACITY - 1);
    localparam logic [POS_W-1:0] POS_PREFIX = POS_W'(PREFIX_LEN);

    // configuration
    logic signed [31:0] min_reg;
    logic signed [31:0] max_reg;

    // input register
    logic        in_valid_reg;
    logic [7:0]  byte_reg;

    // parser state
    logic [POS_W-1:0] pos_reg, pos_next;
    logic             prefix_ok_reg, prefix_ok_next;
    logic [1:0]       phase_reg, phase_next;
    logic             neg_reg, neg_next;
    logic [31:0]      mag_reg, mag_next;
    logic             sat_reg, sat_next;
    logic             det_reg, det_next;

    // output register
    logic    out_valid_reg, out_valid_next;
    result_t out_reg;
    result_t result;

    // control
    logic is_newline;
    logic is_digit;
    logic is_blank;
    logic out_free;
    logic proc;
    logic emit;

    // digit arithmetic
    logic [3:0]         digit_val;
    logic [34:0]        mag_times10;
    logic               mag_over;
    logic signed [31:0] line_value;
    logic               in_range;
    logic               line_ok;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_reg <= MIN_DISTANCE_RST;
            max_reg <= MAX_DISTANCE_RST;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_MIN_DISTANCE: min_reg <= cfg_data;
                REG_MAX_DISTANCE: max_reg <= cfg_data;
                default:          ;
            endcase
        end
    end

    // a newline may only be parsed when the result slot is free or draining
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign is_newline    = (byte_reg == CHAR_LF);
    assign proc          = in_valid_reg && (!is_newline || out_free);
    assign s_axis_tready = !in_valid_reg || proc;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            byte_reg <= s_axis_tdata;
        end
    end

    // byte classes
    assign is_digit  = (byte_reg >= CHAR_ZERO) && (byte_reg <= CHAR_NINE);
    assign is_blank  = (byte_reg == CHAR_SPACE) || (byte_reg == CHAR_TAB) ||
                       (byte_reg == CHAR_VT) || (byte_reg == CHAR_FF);
    assign digit_val = byte_reg[3:0];

    // magnitude * 10 + digit, clamped at 2^31
    assign mag_times10 = ({3'b000, mag_reg} << 3) + ({3'b000, mag_reg} << 1)
                       + {31'd0, digit_val};
    assign mag_over    = mag_times10 > {3'b000, MAG_LIMIT};

    // signed value of the line; a clamped magnitude is exactly 2^31
    always_comb
    begin
        if (neg_reg)
        begin
            line_value = -$signed(mag_reg);
        end
        else if (mag_reg[31])
        begin
            line_value = 32'sh7FFF_FFFF;
        end
        else
        begin
            line_value = $signed(mag_reg);
        end
    end

    assign in_range = (line_value >= min_reg) && (line_value <= max_reg);
    assign line_ok  = (pos_reg >= POS_PREFIX) && prefix_ok_reg && in_range;
    assign emit     = proc && is_newline && line_ok;

    assign result.range_cm      = line_value;
    assign result.detecting     = (line_value > 32'sd0);
    assign result.state_changed = (line_value > 32'sd0) != det_reg;

    // parser state update
    always_comb
    begin
        pos_next       = pos_reg;
        prefix_ok_next = prefix_ok_reg;
        phase_next     = phase_reg;
        neg_next       = neg_reg;
        mag_next       = mag_reg;
        sat_next       = sat_reg;
        det_next       = det_reg;

        if (proc && (byte_reg != CHAR_CR))
        begin
            priority if (is_newline || (pos_reg >= POS_LAST))
            begin
                // end of line or overflow: start a fresh line
                pos_next       = '0;
                prefix_ok_next = 1'b1;
                phase_next     = PH_BLANKS;
                neg_next       = 1'b0;
                mag_next       = '0;
                sat_next       = 1'b0;
                if (is_newline && line_ok)
                begin
                    det_next = result.detecting;
                end
            end
            else
            begin
                pos_next = pos_reg + POS_W'(1);
                if (pos_reg < POS_PREFIX)
                begin
                    if (byte_reg != prefix_char(pos_reg[2:0]))
                    begin
                        prefix_ok_next = 1'b0;
                    end
                end
                else
                begin
                    unique case (phase_reg)
                        PH_BLANKS:
                        begin
                            priority if (is_blank)
                            begin
                                phase_next = PH_BLANKS;
                            end
                            else if (byte_reg == CHAR_PLUS || byte_reg == CHAR_MINUS)
                            begin
                                neg_next   = (byte_reg == CHAR_MINUS);
                                phase_next = PH_SIGN;
                            end
                            else if (is_digit)
                            begin
                                phase_next = PH_DIGITS;
                                mag_next   = mag_over ? MAG_LIMIT : mag_times10[31:0];
                                sat_next   = sat_reg || mag_over;
                            end
                            else
                            begin
                                phase_next = PH_DONE;
                            end
                        end
                        PH_SIGN, PH_DIGITS:
                        begin
                            if (is_digit)
                            begin
                                phase_next = PH_DIGITS;
                                mag_next   = mag_over ? MAG_LIMIT : mag_times10[31:0];
                                sat_next   = sat_reg || mag_over;
                            end
                            else
                            begin
                                phase_next = PH_DONE;
                            end
                        end
                        PH_DONE:
                        begin
                            phase_next = PH_DONE;
                        end
                        default:
                        begin
                            phase_next = phase_reg;
                        end
                    endcase
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            prefix_ok_reg <= 1'b1;
            phase_reg     <= PH_BLANKS;
            neg_reg       <= 1'b0;
            mag_reg       <= '0;
            sat_reg       <= 1'b0;
            det_reg       <= 1'b0;
        end
        else
        begin
            pos_reg       <= pos_next;
            prefix_ok_reg <= prefix_ok_next;
            phase_reg     <= phase_next;
            neg_reg       <= neg_next;
            mag_reg       <= mag_next;
            sat_reg       <= sat_next;
            det_reg       <= det_next;
        end
    end

    // result register: loads on a passing newline, clears when taken
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
        if (emit)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_reg <= result;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {6'b000000, out_reg.state_changed, out_reg.detecting,
                            out_reg.range_cm};

endmodule
